// ===== hw/rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared request codes and request format for the voice mixer.
// ----------------------------------------------------------------------------
package spm_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD     = 3'd0,
    MODE_LENGTH   = 3'd1,
    MODE_PLAY     = 3'd2,
    MODE_PLAY_ANY = 3'd3,
    MODE_STOP     = 3'd4,
    MODE_STOP_ALL = 3'd5,
    MODE_TICK     = 3'd6
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [3:0]         slot_id;
    logic [3:0]         voice;
    logic [7:0]         volume;
    logic [11:0]        sample_index;
    logic signed [15:0] sample_value;
    logic [12:0]        sound_length;
  } cmd_t;

endpackage

// ===== hw/rtl/spm_ram.sv =====
// ----------------------------------------------------------------------------
// spm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/spm_fifo.sv =====
// ----------------------------------------------------------------------------
// spm_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module spm_fifo #(
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spm_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output spm_pkg::cmd_t rdata
);

  spm_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/spm_front.sv =====
// ----------------------------------------------------------------------------
// spm_front
// Accepts requests, drops the ones that have no effect, queues the rest.
// ----------------------------------------------------------------------------
module spm_front #(
  parameter int VOICES       = 16,
  parameter int SOUND_SLOTS  = 16,
  parameter int SLOT_SAMPLES = 4096
) (
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_slot_id,
  input  logic [3:0]         in_voice,
  input  logic [7:0]         in_volume,
  input  logic [11:0]        in_sample_index,
  input  logic signed [15:0] in_sample_value,
  input  logic [12:0]        in_sound_length,
  input  logic               q_full,
  output logic               q_push,
  output spm_pkg::cmd_t      q_cmd
);

  logic id_ok, keep;

  assign in_full = q_full;
  assign id_ok   = (32'(in_slot_id) < SOUND_SLOTS);

  always_comb begin
    q_cmd.mode         = spm_pkg::mode_t'(in_mode);
    q_cmd.slot_id      = in_slot_id;
    q_cmd.voice        = in_voice;
    q_cmd.volume       = in_volume;
    q_cmd.sample_index = in_sample_index;
    q_cmd.sample_value = in_sample_value;
    q_cmd.sound_length = in_sound_length;
    unique case (in_mode) inside
      spm_pkg::MODE_LOAD:     keep = id_ok && (32'(in_sample_index) < SLOT_SAMPLES);
      spm_pkg::MODE_LENGTH,
      spm_pkg::MODE_PLAY_ANY: keep = id_ok;
      spm_pkg::MODE_PLAY:     keep = id_ok && (32'(in_voice) < VOICES / 2);
      spm_pkg::MODE_STOP:     keep = (32'(in_voice) < VOICES);
      spm_pkg::MODE_STOP_ALL,
      spm_pkg::MODE_TICK:     keep = 1'b1;
      default:                keep = 1'b0;
    endcase
  end

  assign q_push = in_push && !q_full && keep;

endmodule

// ===== hw/rtl/spm_back.sv =====
// ----------------------------------------------------------------------------
// spm_back
// Executes queued requests: sound tables, voice state, mixing walk.
// ----------------------------------------------------------------------------
module spm_back #(
  parameter int VOICES       = 16,
  parameter int SOUND_SLOTS  = 16,
  parameter int SLOT_SAMPLES = 4096,
  localparam int VW = $clog2(VOICES),
  localparam int SW = $clog2(SOUND_SLOTS),
  localparam int LW = $clog2(SLOT_SAMPLES + 1),
  localparam int AW = $clog2(SOUND_SLOTS * SLOT_SAMPLES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  spm_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_mixed_sample
);

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_MUL, ST_ACC, ST_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [VW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [24:0] prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] out_data_r, out_data_nxt;
  logic [3:0]         sound_r [VOICES];
  logic [3:0]         sound_nxt [VOICES];
  logic [LW-1:0]      pos_r [VOICES];
  logic [LW-1:0]      pos_nxt [VOICES];
  logic [7:0]         gain_r [VOICES];
  logic [7:0]         gain_nxt [VOICES];
  logic [LW-1:0]      len_r [SOUND_SLOTS];
  logic [LW-1:0]      len_nxt [SOUND_SLOTS];
  logic [SOUND_SLOTS-1:0] loaded_r, loaded_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [15:0]        ram_rdata;
  logic               found, last_voice;
  logic [3:0]         cur_sound;
  logic [LW-1:0]      cur_pos;
  logic [39:0]        acc_sum;
  logic [32:0]        acc_q;
  logic signed [31:0] acc_div;
  logic signed [15:0] acc_sat;
  logic [SW-1:0]      cmd_sid;

  spm_ram #(.WIDTH(16), .DEPTH(SOUND_SLOTS * SLOT_SAMPLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.sample_value),
    .rdata (ram_rdata)
  );

  assign out_empty        = !out_valid_r;
  assign out_mixed_sample = out_data_r;
  assign last_voice       = (idx_r == VW'(VOICES - 1));
  assign cur_sound        = sound_r[idx_r];
  assign cur_pos          = pos_r[idx_r];
  assign cmd_sid          = SW'(cmd.slot_id);

  // truncating divide by 128 of acc*128 + product
  assign acc_sum = {acc_r[31], acc_r, 7'b0} + {{15{prod_r[24]}}, prod_r};
  assign acc_q   = acc_sum[39:7] + 33'((acc_sum[39] && (acc_sum[6:0] != '0)) ? 1 : 0);
  assign acc_div = acc_q[31:0];
  assign acc_sat = (acc_r > 32'sd32767) ? 16'sh7fff :
                   (acc_r < -32'sd32768) ? 16'sh8000 : acc_r[15:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    sound_nxt     = sound_r;
    pos_nxt       = pos_r;
    gain_nxt      = gain_r;
    len_nxt       = len_r;
    loaded_nxt    = loaded_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = '0;
    found         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.mode)
            spm_pkg::MODE_LOAD: begin
              ram_we   = 1'b1;
              ram_addr = AW'(SLOT_SAMPLES * int'(cmd.slot_id) + int'(cmd.sample_index));
            end
            spm_pkg::MODE_LENGTH: begin
              len_nxt[cmd_sid]    = (32'(cmd.sound_length) > SLOT_SAMPLES) ?
                                    LW'(SLOT_SAMPLES) : LW'(cmd.sound_length);
              loaded_nxt[cmd_sid] = 1'b1;
            end
            spm_pkg::MODE_PLAY: begin
              if (loaded_r[cmd_sid]) begin
                sound_nxt[VW'(cmd.voice)] = cmd.slot_id;
                pos_nxt[VW'(cmd.voice)]   = '0;
                gain_nxt[VW'(cmd.voice)]  = cmd.volume;
              end
            end
            spm_pkg::MODE_PLAY_ANY: begin
              if (loaded_r[cmd_sid]) begin
                for (int v = VOICES / 2; v < VOICES; v++) begin
                  if (!found && sound_r[v] == '0) begin
                    found        = 1'b1;
                    sound_nxt[v] = cmd.slot_id;
                    pos_nxt[v]   = '0;
                    gain_nxt[v]  = cmd.volume;
                  end
                end
              end
            end
            spm_pkg::MODE_STOP: begin
              sound_nxt[VW'(cmd.voice)] = '0;
              pos_nxt[VW'(cmd.voice)]   = '0;
            end
            spm_pkg::MODE_STOP_ALL: begin
              for (int v = 0; v < VOICES; v++) begin
                sound_nxt[v] = '0;
                pos_nxt[v]   = '0;
              end
            end
            spm_pkg::MODE_TICK: begin
              idx_nxt   = '0;
              acc_nxt   = '0;
              state_nxt = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (cur_sound != '0 && cur_pos < len_r[SW'(cur_sound)]) begin
          ram_addr  = AW'(SLOT_SAMPLES * int'(cur_sound) + int'(cur_pos));
          state_nxt = ST_MUL;
        end else begin
          if (cur_sound != '0) begin
            sound_nxt[idx_r] = '0;
            pos_nxt[idx_r]   = '0;
          end
          if (last_voice) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = $signed(ram_rdata) * $signed({1'b0, gain_r[idx_r]});
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt        = acc_div;
        pos_nxt[idx_r] = cur_pos + 1'b1;
        if (last_voice) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_sat;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      loaded_r    <= '0;
      for (int v = 0; v < VOICES; v++) begin
        sound_r[v] <= '0;
        pos_r[v]   <= '0;
        gain_r[v]  <= '0;
      end
      for (int s = 0; s < SOUND_SLOTS; s++) begin
        len_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      loaded_r    <= loaded_nxt;
      sound_r     <= sound_nxt;
      pos_r       <= pos_nxt;
      gain_r      <= gain_nxt;
      len_r       <= len_nxt;
    end
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== hw/rtl/sample_playback_voice_mixer.sv =====
// ----------------------------------------------------------------------------
// sample_playback_voice_mixer
// Multi-voice PCM playback mixer with per-sound sample slots.
// ----------------------------------------------------------------------------
// Requests enter a four-deep queue and are carried out one at a time. Load,
// length, play, play-any, stop and stop-all requests are carried out in the
// back end's idle state. A tick walks every voice in order: an idle or
// finished voice gets only the read step, an active one the sample memory
// read, gain multiply and accumulate steps; then the mix goes to the result
// register, waiting while an earlier mix is unpopped. The result register
// frees the back end while the mix waits to be popped. Sample memory is not
// cleared at reset; reading a word never loaded returns an arbitrary value.
module sample_playback_voice_mixer #(
  parameter int VOICES       = 16,
  parameter int SOUND_SLOTS  = 16,
  parameter int SLOT_SAMPLES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_slot_id,
  input  logic [3:0]         in_voice,
  input  logic [7:0]         in_volume,
  input  logic [11:0]        in_sample_index,
  input  logic signed [15:0] in_sample_value,
  input  logic [12:0]        in_sound_length,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [15:0] out_mixed_sample
);

  logic          q_push, q_full, q_pop, q_empty;
  spm_pkg::cmd_t q_wcmd, q_rcmd;

  spm_front #(
    .VOICES(VOICES), .SOUND_SLOTS(SOUND_SLOTS), .SLOT_SAMPLES(SLOT_SAMPLES)
  ) u_front (
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_slot_id      (in_slot_id),
    .in_voice        (in_voice),
    .in_volume       (in_volume),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_sound_length (in_sound_length),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_wcmd)
  );

  spm_fifo #(.DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wcmd),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rcmd)
  );

  spm_back #(
    .VOICES(VOICES), .SOUND_SLOTS(SOUND_SLOTS), .SLOT_SAMPLES(SLOT_SAMPLES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (!q_empty),
    .cmd              (q_rcmd),
    .cmd_pop          (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_mixed_sample (out_mixed_sample)
  );

endmodule

// ===== hw/rtl/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks on the voice mixer.
// ----------------------------------------------------------------------------
module spm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [15:0] out_mixed_sample
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_full_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input queue filled without a request");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result withdrawn before pop");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_mixed_sample))
    else $error("result changed before pop");

endmodule

bind sample_playback_voice_mixer spm_checker u_spm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_mixed_sample (out_mixed_sample)
);
